[hdl/epsilon_neighbour_graph_builder_defines.svh]
// assertion macros for the epsilon neighbour graph builder
`ifndef EPSILON_NEIGHBOUR_GRAPH_BUILDER_DEFINES_SVH
`define EPSILON_NEIGHBOUR_GRAPH_BUILDER_DEFINES_SVH

// same-cycle implication
`define ENGB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ENGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/engb_pkg.sv]
// types and constants shared by the epsilon neighbour graph builder
`default_nettype none

package engb_pkg;

   localparam int POINT_IDX_W  = 3;
   localparam int DIM_IDX_W    = 2;
   localparam int COORD_IN_W   = 16;
   localparam int RADIUS_W     = 16;
   localparam int LIMIT_W      = 2 * RADIUS_W;
   localparam int POINTS_CFG_W = 4;
   localparam int DIMS_CFG_W   = 3;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 4;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_BUILD = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE   = 1'd1;

   localparam logic [POINTS_CFG_W-1:0] POINTS_RESET = 4'd8;
   localparam logic [DIMS_CFG_W-1:0]   DIMS_RESET   = 3'd4;

   typedef struct packed {
      logic [1:0]                    kind;
      logic [POINT_IDX_W-1:0]        point_index;
      logic [DIM_IDX_W-1:0]          dim_index;
      logic signed [COORD_IN_W-1:0]  coord_value;
      logic [RADIUS_W-1:0]           radius;
   } engb_req_type;

   typedef struct packed {
      logic [POINT_IDX_W-1:0] low_vertex;
      logic [POINT_IDX_W-1:0] high_vertex;
      logic                   edge_valid;
      logic                   last;
   } engb_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_PAIR,
      ST_ISSUE,
      ST_DRAIN,
      ST_DECIDE,
      ST_FLUSH
   } engb_state_type;

   typedef struct packed {
      logic load;
      logic clear_edges;
      logic start;
      logic acc_clear;
      logic issue;
      logic mark_edge;
      logic hold_new;
      logic emit_pending;
      logic emit_final;
   } engb_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic pair_ok;
      logic edge_set;
      logic out_free;
      logic pend_valid;
   } engb_stat_type;

endpackage

`default_nettype wire

[hdl/engb_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module engb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/engb_datapath.sv]
// coordinate store, distance pipeline, edge bits and output register
`default_nettype none

module engb_datapath #(
   parameter int MAX_POINTS  = 8,
   parameter int MAX_DIMS    = 4,
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire engb_pkg::engb_req_type                      req_data,
   input  wire engb_pkg::engb_cmd_type                      cmd,
   output engb_pkg::engb_stat_type                          stat,
   input  wire logic [$clog2(MAX_POINTS)-1:0]               rd_point_a,
   input  wire logic [$clog2(MAX_POINTS)-1:0]               rd_point_b,
   input  wire logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] rd_dim,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output engb_pkg::engb_rsp_type                           rsp_data
);

   import engb_pkg::*;

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int AW     = PW + DW;
   localparam int DEPTH  = 2 ** AW;
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int CMP_W  = (DIFF_W > RADIUS_W) ? DIFF_W : RADIUS_W;
   localparam int SUM_W  = LIMIT_W + $clog2(MAX_DIMS + 1);

   // coordinate store
   logic                   load_ok;
   logic [AW-1:0]          wr_addr;
   logic [COORD_WIDTH-1:0] wr_coord;
   logic [COORD_WIDTH-1:0] coord_a;
   logic [COORD_WIDTH-1:0] coord_b;

   assign load_ok  = cmd.load && (32'(req_data.point_index) < MAX_POINTS)
                     && (32'(req_data.dim_index) < MAX_DIMS);
   assign wr_addr  = {PW'(req_data.point_index), DW'(req_data.dim_index)};
   assign wr_coord = COORD_WIDTH'(req_data.coord_value);

   engb_ram #(.WIDTH(COORD_WIDTH), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_coord),
      .rd_addr ({rd_point_a, rd_dim}),
      .rd_data (coord_a)
   );

   engb_ram #(.WIDTH(COORD_WIDTH), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_coord),
      .rd_addr ({rd_point_b, rd_dim}),
      .rd_data (coord_b)
   );

   // radius and squared limit
   logic [RADIUS_W-1:0] radius_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         radius_ff <= req_data.radius;
      end
      limit_ff <= LIMIT_W'(32'(radius_ff) * 32'(radius_ff));
   end

   // distance pipeline
   logic signed [COORD_WIDTH-1:0] coord_a_s;
   logic signed [COORD_WIDTH-1:0] coord_b_s;
   logic signed [DIFF_W-1:0]      diff;
   logic [DIFF_W-1:0]             mag;
   logic [CMP_W-1:0]              mag_ext;
   logic                          far;

   assign coord_a_s = coord_a;
   assign coord_b_s = coord_b;
   assign diff      = DIFF_W'(coord_a_s) - DIFF_W'(coord_b_s);
   assign mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign mag_ext   = CMP_W'(mag);
   assign far       = mag_ext > CMP_W'(radius_ff);

   logic                v1_ff;
   logic                v2_ff;
   logic                v3_ff;
   logic [RADIUS_W-1:0] op_ff;
   logic                far2_ff;
   logic [LIMIT_W-1:0]  prod_ff;
   logic                far3_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic                fail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= mag_ext[RADIUS_W-1:0];
      far2_ff <= far;
      prod_ff <= LIMIT_W'(32'(op_ff) * 32'(op_ff));
      far3_ff <= far2_ff;
      if (cmd.acc_clear) begin
         sum_ff  <= '0;
         fail_ff <= 1'b0;
      end else if (v3_ff) begin
         sum_ff  <= sum_ff + SUM_W'(prod_ff);
         fail_ff <= fail_ff | far3_ff;
      end
   end

   // edge bits
   logic [MAX_POINTS-1:0][MAX_POINTS-1:0] edge_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_edges) begin
         edge_ff <= '0;
      end else if (cmd.mark_edge) begin
         edge_ff[rd_point_a][rd_point_b] <= 1'b1;
      end
   end

   // pending edge and output register
   logic                   pend_valid_ff;
   logic [POINT_IDX_W-1:0] pend_lo_ff;
   logic [POINT_IDX_W-1:0] pend_hi_ff;
   logic                   rsp_valid_ff;
   engb_rsp_type           rsp_data_ff;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.start || cmd.emit_final) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.hold_new) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_new) begin
         pend_lo_ff <= POINT_IDX_W'(rd_point_a);
         pend_hi_ff <= POINT_IDX_W'(rd_point_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_pending || cmd.emit_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pending) begin
         rsp_data_ff <= '{low_vertex: pend_lo_ff, high_vertex: pend_hi_ff,
                          edge_valid: 1'b1, last: 1'b0};
      end else if (cmd.emit_final) begin
         if (pend_valid_ff) begin
            rsp_data_ff <= '{low_vertex: pend_lo_ff, high_vertex: pend_hi_ff,
                             edge_valid: 1'b1, last: 1'b1};
         end else begin
            rsp_data_ff <= '{low_vertex: '0, high_vertex: '0,
                             edge_valid: 1'b0, last: 1'b1};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat.pipe_busy  = v1_ff || v2_ff || v3_ff;
   assign stat.pair_ok    = !fail_ff && (sum_ff <= SUM_W'(limit_ff));
   assign stat.edge_set   = edge_ff[rd_point_a][rd_point_b];
   assign stat.out_free   = out_free;
   assign stat.pend_valid = pend_valid_ff;

endmodule

`default_nettype wire

[hdl/engb_controller.sv]
// control state machine, pair and axis counters, configuration registers
`default_nettype none

module engb_controller #(
   parameter int MAX_POINTS = 8,
   parameter int MAX_DIMS   = 4
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire engb_pkg::engb_req_type                      req_data,
   input  wire logic                                        csr_we,
   input  wire logic [engb_pkg::CSR_IDX_W-1:0]              csr_index,
   input  wire logic [engb_pkg::CSR_DATA_W-1:0]             csr_wdata,
   output engb_pkg::engb_cmd_type                           cmd,
   input  wire engb_pkg::engb_stat_type                     stat,
   output logic [$clog2(MAX_POINTS)-1:0]                    rd_point_a,
   output logic [$clog2(MAX_POINTS)-1:0]                    rd_point_b,
   output logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] rd_dim
);

   import engb_pkg::*;

   localparam int PW  = $clog2(MAX_POINTS);
   localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int DCW = $clog2(MAX_DIMS + 1);

   // configuration registers
   logic [POINTS_CFG_W-1:0] points_ff;
   logic [DIMS_CFG_W-1:0]   dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= POINTS_RESET;
         dims_ff   <= DIMS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POINTS_IN_USE: points_ff <= csr_wdata[POINTS_CFG_W-1:0];
            CSR_DIMS_IN_USE:   dims_ff   <= csr_wdata[DIMS_CFG_W-1:0];
            default:           points_ff <= points_ff;
         endcase
      end
   end

   // state and counters
   engb_state_type state_ff, state_in;
   logic [PW-1:0]  i_ff, i_in;
   logic [PW-1:0]  j_ff, j_in;
   logic [DW-1:0]  d_ff, d_in;
   logic [PCW-1:0] np_ff, np_in;
   logic [DCW-1:0] nd_ff, nd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      d_ff  <= d_in;
      np_ff <= np_in;
      nd_ff <= nd_in;
   end

   logic accept;
   logic more_j;
   logic more_i;
   logic more_d;
   logic new_edge;
   logic blocked;

   assign accept   = req_valid && !req_stall;
   assign more_j   = (PCW'(j_ff) + PCW'(1)) < np_ff;
   assign more_i   = (PCW'(i_ff) + PCW'(2)) < np_ff;
   assign more_d   = (DCW'(d_ff) + DCW'(1)) < nd_ff;
   assign new_edge = !stat.edge_set && stat.pair_ok;
   assign blocked  = new_edge && stat.pend_valid && !stat.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      d_in     = d_ff;
      np_in    = np_ff;
      nd_in    = nd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_BUILD) begin
               state_in = ST_LIMIT;
               i_in     = '0;
               j_in     = PW'(1);
               np_in    = (32'(points_ff) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(points_ff);
               nd_in    = (32'(dims_ff) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(dims_ff);
            end
         end
         ST_LIMIT: begin
            state_in = (np_ff < PCW'(2)) ? ST_FLUSH : ST_PAIR;
         end
         ST_PAIR: begin
            d_in     = '0;
            state_in = (nd_ff == '0) ? ST_DRAIN : ST_ISSUE;
         end
         ST_ISSUE: begin
            if (more_d) begin
               d_in = d_ff + DW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!blocked) begin
               priority if (more_j) begin
                  j_in     = j_ff + PW'(1);
                  state_in = ST_PAIR;
               end else if (more_i) begin
                  i_in     = i_ff + PW'(1);
                  j_in     = PW'(PCW'(i_ff) + PCW'(2));
                  state_in = ST_PAIR;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.load        = accept && req_data.kind == KIND_LOAD;
            cmd.clear_edges = accept && req_data.kind == KIND_CLEAR;
            cmd.start       = accept && req_data.kind == KIND_BUILD;
         end
         ST_LIMIT: begin
            cmd = '0;
         end
         ST_PAIR: begin
            cmd.acc_clear = 1'b1;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_DECIDE: begin
            if (new_edge && !blocked) begin
               cmd.mark_edge    = 1'b1;
               cmd.hold_new     = 1'b1;
               cmd.emit_pending = stat.pend_valid;
            end
         end
         ST_FLUSH: begin
            cmd.emit_final = stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

   assign rd_point_a = i_ff;
   assign rd_point_b = j_ff;
   assign rd_dim     = d_ff;

endmodule

`default_nettype wire

[hdl/epsilon_neighbour_graph_builder.sv]
// Epsilon neighbour graph builder. Load items write one coordinate each and clear items
// drop all edges. A build item scans every pair i<j of the points in use, reading one
// axis of both points per cycle from two copies of the coordinate store into a pipeline
// of subtract, square and accumulate. Each newly added edge leaves as one word, the
// final word of a build flagged last, or a single no-edge word when nothing was added.
// No new item is taken during a build.
`default_nettype none

`include "epsilon_neighbour_graph_builder_defines.svh"

module epsilon_neighbour_graph_builder #(
   parameter int MAX_POINTS  = 8,
   parameter int MAX_DIMS    = 4,
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire engb_pkg::engb_req_type            req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output engb_pkg::engb_rsp_type                 rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [engb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [engb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import engb_pkg::*;

   localparam int PW = $clog2(MAX_POINTS);
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   engb_cmd_type  cmd;
   engb_stat_type stat;
   logic [PW-1:0] rd_point_a;
   logic [PW-1:0] rd_point_b;
   logic [DW-1:0] rd_dim;

   engb_controller #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rd_point_a (rd_point_a),
      .rd_point_b (rd_point_b),
      .rd_dim     (rd_dim)
   );

   engb_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_DIMS    (MAX_DIMS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rd_point_a (rd_point_a),
      .rd_point_b (rd_point_b),
      .rd_dim     (rd_dim),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   `ENGB_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit_pending || cmd.emit_final, stat.out_free, "word pushed into a full output register")
   `ENGB_ASSERT_NOW(a_mark_new, clock, reset, cmd.mark_edge, !stat.edge_set && stat.pair_ok && !stat.pipe_busy, "edge marked without a passing distance")
   `ENGB_ASSERT_NEXT(a_build_busy, clock, reset, req_valid && !req_stall && req_data.kind == KIND_BUILD, req_stall, "input taken during a build")

endmodule

`default_nettype wire
